// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset disable
`define GBN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// implication on one clock, same disable
`define GBN_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

`endif

// ----- hdl/gbn_pkg.sv -----
// types, constants and codes shared by the box suppression block
package gbn_pkg;

  localparam int unsigned MaxKeptDef = 64;
  localparam int unsigned ThrW       = 9;
  localparam logic [ThrW-1:0] ThrReset = 9'd115;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned SizeW      = 15;
  localparam int unsigned AreaW      = 30;
  localparam int unsigned InDataW    = 64;
  localparam int unsigned OutDataW   = 8;
  localparam int unsigned SlotW      = 6;

  typedef struct packed {
    logic [SizeW-1:0]         height;
    logic [SizeW-1:0]         width;
    logic signed [CoordW-1:0] top;
    logic signed [CoordW-1:0] left;
  } box_t;

  typedef struct packed {
    logic             new_set;
    box_t             box;
    logic [AreaW-1:0] area;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

endpackage

// ----- hdl/gbn_front.sv -----
// front end: decodes input beats, computes box area, two-entry queue
module gbn_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [gbn_pkg::InDataW-1:0] s_axis_tdata,
  input  logic                       s_axis_tuser,
  output logic                       q_valid_o,
  input  logic                       q_ready_i,
  output gbn_pkg::item_t             q_item_o
);
  import gbn_pkg::*;

  item_t      mem_q [2];
  item_t      entry;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  // decode the beat and compute its area
  always_comb begin
    entry.new_set    = s_axis_tuser;
    entry.box.left   = s_axis_tdata[15:0];
    entry.box.top    = s_axis_tdata[31:16];
    entry.box.width  = s_axis_tdata[46:32];
    entry.box.height = s_axis_tdata[61:47];
    entry.area       = {15'b0, s_axis_tdata[46:32]} * {15'b0, s_axis_tdata[61:47]};
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign pop           = q_valid_o && q_ready_i;
  assign q_item_o      = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hdl/gbn_back.sv -----
// back end: walks the kept-box store through a pipelined overlap unit
module gbn_back #(
  parameter int unsigned MaxKept = gbn_pkg::MaxKeptDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gbn_pkg::ThrW-1:0]     cfg_wdata_i,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  gbn_pkg::item_t               q_item_i,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [gbn_pkg::OutDataW-1:0] m_axis_tdata
);
  import gbn_pkg::*;

  localparam int unsigned AW = (MaxKept > 1) ? $clog2(MaxKept) : 1;
  localparam int unsigned CW = $clog2(MaxKept + 1);

  // kept-box store
  box_t             box_mem [MaxKept];
  logic [AreaW-1:0] area_mem [MaxKept];

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [ThrW-1:0]  thr_q;
  item_t            cur_q;
  logic             supp_q, supp_d;
  logic             out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic             issue, wr_en, has_room, load_out;
  logic [CW+SlotW-1:0] slot_ext;

  // pipeline registers
  logic                    v1_q, v2_q, v3_q, v4_q, v5_q;
  box_t                    rd_box_q;
  logic [AreaW-1:0]        rd_area_q, s2_area_q, s3_area_q;
  logic signed [16:0]      x0_q, y0_q, x1_q, y1_q;
  logic [AreaW-1:0]        inter3_q, inter4_q;
  logic [AreaW:0]          uni_q;
  logic [39:0]             prod_q, inter256_q;

  // stage arithmetic
  logic signed [16:0] nl, nt, sl, st, nr, nb, sr, sb;
  logic signed [17:0] dx, dy;
  logic [SizeW-1:0]   dxc, dyc;

  assign q_ready_o     = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign issue         = (state_q == ST_RUN) && (idx_q != cnt_q);
  assign has_room      = (cnt_q < CW'(MaxKept));
  assign load_out      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign wr_en         = load_out && !supp_q && has_room;
  assign slot_ext      = {{SlotW{1'b0}}, cnt_q};

  // rectangle edges of the new and the stored box
  always_comb begin
    nl = {cur_q.box.left[15], cur_q.box.left};
    nt = {cur_q.box.top[15], cur_q.box.top};
    sl = {rd_box_q.left[15], rd_box_q.left};
    st = {rd_box_q.top[15], rd_box_q.top};
    nr = nl + $signed({2'b00, cur_q.box.width});
    nb = nt + $signed({2'b00, cur_q.box.height});
    sr = sl + $signed({2'b00, rd_box_q.width});
    sb = st + $signed({2'b00, rd_box_q.height});
    dx = {x1_q[16], x1_q} - {x0_q[16], x0_q};
    dy = {y1_q[16], y1_q} - {y0_q[16], y0_q};
    dxc = (dx > 18'sd0) ? dx[SizeW-1:0] : '0;
    dyc = (dy > 18'sd0) ? dy[SizeW-1:0] : '0;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    supp_d      = supp_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.new_set) cnt_d = '0;
          idx_d   = '0;
          supp_d  = 1'b0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue) idx_d = idx_q + 1'b1;
        else       state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!(v1_q || v2_q || v3_q || v4_q || v5_q)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          if (!supp_q) begin
            out_data_d[0] = 1'b1;
            if (has_room) begin
              out_data_d[SlotW:1] = slot_ext[SlotW-1:0];
              cnt_d = cnt_q + 1'b1;
            end else begin
              out_data_d[SlotW+1] = 1'b1;
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (v5_q && (inter256_q > prod_q)) supp_d = 1'b1;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      supp_q      <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= ThrReset;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      supp_q      <= supp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // payload registers and store access
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (state_q == ST_IDLE && q_valid_i) cur_q <= q_item_i;
    if (wr_en) begin
      box_mem[cnt_q[AW-1:0]]  <= cur_q.box;
      area_mem[cnt_q[AW-1:0]] <= cur_q.area;
    end
    rd_box_q  <= box_mem[idx_q[AW-1:0]];
    rd_area_q <= area_mem[idx_q[AW-1:0]];
    // overlap corners
    x0_q <= (nl > sl) ? nl : sl;
    y0_q <= (nt > st) ? nt : st;
    x1_q <= (nr < sr) ? nr : sr;
    y1_q <= (nb < sb) ? nb : sb;
    s2_area_q <= rd_area_q;
    // intersection area
    inter3_q  <= {15'b0, dxc} * {15'b0, dyc};
    s3_area_q <= s2_area_q;
    // union
    uni_q    <= {1'b0, cur_q.area} + {1'b0, s3_area_q} - {1'b0, inter3_q};
    inter4_q <= inter3_q;
    // threshold products
    prod_q     <= {31'b0, thr_q} * {9'b0, uni_q};
    inter256_q <= {2'b0, inter4_q, 8'b0};
  end

endmodule

// ----- hdl/greedy_box_nms_top.sv -----
// each box is compared, after the front queue, with the N boxes held in the store
// of the current set; a stall on the result port holds its result beat
// one box is handled at a time by the single pipelined overlap unit,
// which reads one stored box per cycle from the store memory
// a two-beat queue in front takes new boxes while one is being compared
// reset empties the store, sets the threshold to 115 and drops queued beats
module greedy_box_nms_top #(
  parameter int unsigned MaxKept = gbn_pkg::MaxKeptDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gbn_pkg::ThrW-1:0]      cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // left[15:0], top[31:16], width[46:32], height[61:47], zero[63:62]
  input  logic [gbn_pkg::InDataW-1:0]   s_axis_tdata,
  // new_set
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // keep[0], slot_index[6:1], store_full[7]
  output logic [gbn_pkg::OutDataW-1:0]  m_axis_tdata
);
  import gbn_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;

  // beat intake and queue
  gbn_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  // store walk and decision
  gbn_back #(.MaxKept(MaxKept)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

endmodule

// ----- hdl/gbn_checker.sv -----
// port-level checks for the box suppression block, bound to the top level
`include "assert_macros.svh"
module gbn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  // a stalled result beat holds
  `GBN_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "result beat changed while stalled")
  // a suppressed box carries no slot and no full flag
  `GBN_ASSERT_IMPL(a_drop_clean, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[7:1] == 7'd0, "suppressed box with slot or full flag")
  // a full flag only on a kept box with slot zero
  `GBN_ASSERT_IMPL(a_full_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[7], m_axis_tdata[0] && (m_axis_tdata[6:1] == 6'd0), "bad full flag beat")
endmodule

bind greedy_box_nms_top gbn_checker u_gbn_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
